// ===== rtl/core/dmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpc_pkg - shared types and constants of the damper motor position control
// mode codes, special target and position values, divider result bundle
// ----------------------------------------------------------------------------
`default_nettype none

package dmpc_pkg;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_OPENING = 3'd1;
    localparam logic [2:0] MODE_CLOSING = 3'd2;
    localparam logic [2:0] MODE_OPEN    = 3'd3;
    localparam logic [2:0] MODE_CLOSED  = 3'd4;

    localparam logic [7:0] POS_UNKNOWN      = 8'd255;
    localparam logic [7:0] TARGET_STOP      = 8'd255;
    localparam logic [7:0] TARGET_REFERENCE = 8'd101;
    localparam logic [7:0] FULL_PERCENT     = 8'd100;

    // dividend is run time times one hundred
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DVD_W   = 39;
    localparam int unsigned QUOT_W  = 7;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } dmpc_div_res_t;

endpackage : dmpc_pkg

`default_nettype wire

// ===== rtl/core/dmpc_div.sv =====
// ----------------------------------------------------------------------------
// dmpc_div - bit-serial restoring divider for the run-time estimate
// one quotient bit per cycle, quotient saturation flagged above 100
// ----------------------------------------------------------------------------
`default_nettype none

module dmpc_div
    import dmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output dmpc_div_res_t          res
);

    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              ovf_reg, ovf_next;
    logic              done_reg, done_next;

    logic [TIME_W:0]   rem_sh;
    logic              fits;

    // shift in next dividend bit, trial subtract
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next  = fits ? TIME_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[TIME_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            // any quotient bit above the low ones means more than 100
            ovf_next  = ovf_reg | quot_reg[QUOT_W-1];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    // a zero divisor yields all ones quotient, so it saturates by itself
    assign res.done = done_reg;
    assign res.sat  = ovf_reg || (quot_reg > QUOT_W'(FULL_PERCENT));
    assign res.quot = quot_reg;

endmodule : dmpc_div

`default_nettype wire

// ===== rtl/core/damper_motor_position_control.sv =====
// ----------------------------------------------------------------------------
// damper_motor_position_control - damper motor drive sequencer with estimate
// five-mode motor control, end switches, start delay, run-time position
// ----------------------------------------------------------------------------
// throughput: a new tick is taken only once the previous beat has been handed off,
//             and a tick that needs an estimate first waits for the 39-step serial
//             divider
// reset: asynchronous, active low; control and configuration registers return to
//        their default values, mode idle, position unknown, target stop, drives off
// ----------------------------------------------------------------------------
`default_nettype none

module damper_motor_position_control
    import dmpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    // tick input
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // now_ms[31:0], open_switch_level[32], closed_switch_level[33],
    // command_valid[34], command_target[42:35], zero[47:43]
    input  wire logic [47:0] s_axis_tdata,
    // result output
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // drive_open_pin[0], drive_close_pin[1], mode[4:2],
    // position_percent[12:5], zero[15:13]
    output      logic [15:0] m_axis_tdata
);

    // register indexes
    localparam logic [2:0] REG_START_DELAY = 3'd0;
    localparam logic [2:0] REG_OPEN_TIME   = 3'd1;
    localparam logic [2:0] REG_CLOSE_TIME  = 3'd2;
    localparam logic [2:0] REG_DRIVE_LOW   = 3'd3;
    localparam logic [2:0] REG_SWITCH_LOW  = 3'd4;
    localparam logic [2:0] REG_SIM_MODE    = 3'd5;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]       start_delay_reg;
    logic [TIME_W-1:0] open_time_reg;
    logic [TIME_W-1:0] close_time_reg;
    logic              drive_low_reg;
    logic              switch_low_reg;
    logic              sim_mode_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= 16'd500;
            open_time_reg   <= 32'd60000;
            close_time_reg  <= 32'd60000;
            drive_low_reg   <= 1'b0;
            switch_low_reg  <= 1'b0;
            sim_mode_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_START_DELAY: start_delay_reg <= pwdata[15:0];
                REG_OPEN_TIME:   open_time_reg   <= pwdata;
                REG_CLOSE_TIME:  close_time_reg  <= pwdata;
                REG_DRIVE_LOW:   drive_low_reg   <= pwdata[0];
                REG_SWITCH_LOW:  switch_low_reg  <= pwdata[0];
                REG_SIM_MODE:    sim_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_START_DELAY: prdata = {16'd0, start_delay_reg};
            REG_OPEN_TIME:   prdata = open_time_reg;
            REG_CLOSE_TIME:  prdata = close_time_reg;
            REG_DRIVE_LOW:   prdata = {31'd0, drive_low_reg};
            REG_SWITCH_LOW:  prdata = {31'd0, switch_low_reg};
            REG_SIM_MODE:    prdata = {31'd0, sim_mode_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [1:0]        state_reg, state_next;
    logic [2:0]        mode_reg, mode_next;
    logic              first_tick_reg;
    logic [TIME_W-1:0] entry_time_reg, entry_time_next;
    logic [TIME_W-1:0] run_start_reg, run_start_next;
    logic              run_started_reg, run_started_next;
    logic [7:0]        target_reg, target_next;
    logic [7:0]        position_reg, position_next;
    logic              drv_open_reg, drv_open_next;
    logic              drv_close_reg, drv_close_next;
    logic              div_opening_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;

    logic              in_beat;
    logic              out_free;

    // tick fields
    logic [TIME_W-1:0] now;
    logic              at_open;
    logic              at_closed;
    logic              tgt_live;
    logic              delay_ok;
    logic              opening;
    logic [7:0]        pos_sim;
    logic              need_div;
    logic [TIME_W-1:0] elapsed;
    logic [DVD_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
    dmpc_div_res_t     div_res;
    logic [7:0]        est_pos;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign now       = s_axis_tdata[31:0];
    assign at_open   = s_axis_tdata[32] ^ switch_low_reg;
    assign at_closed = s_axis_tdata[33] ^ switch_low_reg;

    // command is applied before the tick logic
    assign target_next = s_axis_tdata[34] ? s_axis_tdata[42:35] : target_reg;
    assign tgt_live    = target_next != TARGET_STOP;

    // entry time is taken only on the first tick after reset
    assign entry_time_next = first_tick_reg ? now : entry_time_reg;
    assign delay_ok        = (now - entry_time_next) > {16'd0, start_delay_reg};
    assign opening         = (mode_reg == MODE_OPENING);

    // mode logic of one tick
    always_comb
    begin
        mode_next        = mode_reg;
        run_start_next   = run_start_reg;
        run_started_next = run_started_reg;
        drv_open_next    = drv_open_reg;
        drv_close_next   = drv_close_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                drv_open_next    = 1'b0;
                drv_close_next   = 1'b0;
                run_started_next = 1'b0;
                if (at_open)
                    mode_next = MODE_OPEN;
                else if (at_closed)
                    mode_next = MODE_CLOSED;
                else if (position_reg == POS_UNKNOWN)
                begin
                    if (target_next == TARGET_REFERENCE)
                        mode_next = MODE_OPENING;
                end
                else if (target_next > position_reg && tgt_live)
                    mode_next = MODE_OPENING;
                else if (target_next < position_reg && tgt_live)
                    mode_next = MODE_CLOSING;
            end
            MODE_OPENING, MODE_CLOSING:
            begin
                if (delay_ok)
                begin
                    drv_open_next  = opening;
                    drv_close_next = !opening;
                    if (!run_started_reg)
                    begin
                        run_start_next   = now;
                        run_started_next = 1'b1;
                    end
                end
                if (opening ? at_open : at_closed)
                begin
                    drv_open_next  = 1'b0;
                    drv_close_next = 1'b0;
                    mode_next      = opening ? MODE_OPEN : MODE_CLOSED;
                end
                else if ((opening ? (position_reg >= target_next)
                                  : (position_reg <= target_next))
                         || !tgt_live)
                begin
                    drv_open_next  = 1'b0;
                    drv_close_next = 1'b0;
                    mode_next      = MODE_IDLE;
                end
                else if ((opening ? (target_next < position_reg)
                                  : (target_next > position_reg)) && tgt_live)
                begin
                    // reversal keeps the running start time
                    drv_open_next  = 1'b0;
                    drv_close_next = 1'b0;
                    mode_next      = opening ? MODE_CLOSING : MODE_OPENING;
                end
            end
            MODE_OPEN:
            begin
                drv_open_next    = 1'b0;
                drv_close_next   = 1'b0;
                run_started_next = 1'b0;
                if (target_next < position_reg && tgt_live)
                    mode_next = MODE_CLOSING;
            end
            MODE_CLOSED:
            begin
                drv_open_next    = 1'b0;
                drv_close_next   = 1'b0;
                run_started_next = 1'b0;
                if (target_next > position_reg && tgt_live)
                    mode_next = MODE_OPENING;
            end
            default: ;
        endcase
    end

    // simulation referencing, end-switch override, estimate request
    assign pos_sim = (sim_mode_reg && position_reg == POS_UNKNOWN) ? FULL_PERCENT
                                                                  : position_reg;
    assign position_next = at_open   ? FULL_PERCENT :
                           at_closed ? 8'd0 : pos_sim;
    assign need_div = !at_open && !at_closed && pos_sim != POS_UNKNOWN
                      && run_started_next
                      && (mode_next == MODE_OPENING || mode_next == MODE_CLOSING);

    assign elapsed  = now - run_start_next;
    // exact product, 39 bits hold 100 times any 32-bit run time
    assign dividend = DVD_W'(elapsed) * DVD_W'(FULL_PERCENT);
    assign divisor  = (mode_next == MODE_OPENING) ? open_time_reg : close_time_reg;

    dmpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_beat && need_div),
        .dividend (dividend),
        .divisor  (divisor),
        .res      (div_res)
    );

    // opening clamps at full, closing counts down and floors at zero
    always_comb
    begin
        if (div_opening_reg)
            est_pos = div_res.sat ? FULL_PERCENT : {1'b0, div_res.quot};
        else if (div_res.sat || {1'b0, div_res.quot} >= FULL_PERCENT)
            est_pos = 8'd0;
        else
            est_pos = FULL_PERCENT - {1'b0, div_res.quot};
    end

    // sequencer: take tick, optionally wait for the divider, hand off beat
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_beat)
                    state_next = need_div ? ST_DIV : ST_OUT;
            ST_DIV:
                if (div_res.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_IDLE;
            first_tick_reg  <= 1'b1;
            entry_time_reg  <= '0;
            run_start_reg   <= '0;
            run_started_reg <= 1'b0;
            target_reg      <= TARGET_STOP;
            position_reg    <= POS_UNKNOWN;
            drv_open_reg    <= 1'b0;
            drv_close_reg   <= 1'b0;
            div_opening_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_beat)
            begin
                mode_reg        <= mode_next;
                first_tick_reg  <= 1'b0;
                entry_time_reg  <= entry_time_next;
                run_start_reg   <= run_start_next;
                run_started_reg <= run_started_next;
                target_reg      <= target_next;
                position_reg    <= position_next;
                drv_open_reg    <= drv_open_next;
                drv_close_reg   <= drv_close_next;
                div_opening_reg <= (mode_next == MODE_OPENING);
            end
            else if (state_reg == ST_DIV && div_res.done)
                position_reg <= est_pos;

            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result beat, drive polarity applied at the pins
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
            out_data_reg <= {3'd0, position_reg, mode_reg,
                             drv_close_reg ^ drive_low_reg,
                             drv_open_reg ^ drive_low_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule : damper_motor_position_control

`default_nettype wire
